FILE: rtl/skr_pkg.sv
// Package for the keyed-removal stack: transfer structs, action and status codes,
// and the cell control struct.
// No dependencies.
package skr_pkg;

  localparam int unsigned ValueW = 16;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LIST   = 2'd2;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_LISTED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ValueW-1:0] item_value;
    logic [ValueW-1:0] search_key;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] entry_value;
    logic [3:0]        entry_position;
    logic [4:0]        occupancy;
    logic              last;
  } result_t;

  // per-cell load controls: from the cell above (push) or below (close gap / rotate)
  typedef struct packed {
    logic load_up;
    logic load_dn;
  } cell_ctrl_t;

endpackage

FILE: rtl/skr_cell.sv
// One stack cell: holds one entry, compares it against the search key and
// loads from its upper or lower neighbor. Depends on skr_pkg.
module skr_cell (
  input  logic                      clk_i,
  input  skr_pkg::cell_ctrl_t       ctrl_i,
  input  logic [skr_pkg::ValueW-1:0] up_i,
  input  logic [skr_pkg::ValueW-1:0] dn_i,
  input  logic [skr_pkg::ValueW-1:0] key_i,
  input  logic                      in_range_i,
  output logic [skr_pkg::ValueW-1:0] value_o,
  output logic                      hit_o
);
  import skr_pkg::*;

  logic [ValueW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load_up) begin
      value_d = up_i;
    end else if (ctrl_i.load_dn) begin
      value_d = dn_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign hit_o   = in_range_i && (value_q == key_i);

endmodule

FILE: rtl/stack_with_keyed_removal_core.sv
// Keyed-removal stack core: a chain of skr_cell (cell 0 holds the top entry); uses skr_pkg.
// Push, remove, unused actions and a list of an empty stack: one result, strobed in the
// cycle after the accepting edge; busy stays low, so a new item can be taken every cycle.
// List of N entries: N results, one per cycle, each registered during the listing state;
// busy is high in that state, and the entries rotate once through the chain.
// Reset clears the count and pending results, not the entries; results cannot be stalled.
module stack_with_keyed_removal_core #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  skr_pkg::item_t   item_i,
  output logic             res_valid_o,
  output skr_pkg::result_t res_o
);
  import skr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  logic [CW-1:0]     count_q, count_d;
  logic              listing_q, listing_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  logic [ValueW-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]  hit;
  logic [DEPTH-1:0]  sel;

  logic accept, is_push, is_remove, is_list, full, found, empty;
  logic do_push, do_remove, last_list;

  assign accept    = start && !busy;
  assign is_push   = accept && (item_i.action == ACT_PUSH);
  assign is_remove = accept && (item_i.action == ACT_REMOVE);
  assign is_list   = accept && (item_i.action == ACT_LIST);
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign found     = sel[DEPTH-1];
  assign do_push   = is_push && !full;
  assign do_remove = is_remove && found;
  assign last_list = listing_q && ((CW'(pos_q) + CW'(1)) == count_q);

  // sel marks the topmost hit and every cell below it
  always_comb begin
    sel[0] = hit[0];
    for (int k = 1; k < DEPTH; k++) begin
      sel[k] = sel[k-1] | hit[k];
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ValueW-1:0] up, dn;
    cell_ctrl_t        ctrl;

    if (k == 0) begin : g_top
      assign up = item_i.item_value;
    end else begin : g_mid
      assign up = cell_val[k-1];
    end

    // lowest held cell wraps to the top entry during a listing rotation
    if (k == DEPTH - 1) begin : g_bot
      assign dn = cell_val[0];
    end else begin : g_nbot
      assign dn = (count_q == CW'(k + 1)) ? cell_val[0] : cell_val[k+1];
    end

    assign ctrl.load_up = do_push;
    assign ctrl.load_dn = listing_q || (do_remove && sel[k]);

    skr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .up_i       (up),
      .dn_i       (dn),
      .key_i      (item_i.search_key),
      .in_range_i (CW'(k) < count_q),
      .value_o    (cell_val[k]),
      .hit_o      (hit[k])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CW'(1);
    end else if (do_remove) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    listing_d = listing_q;
    pos_d     = pos_q;
    if (accept) begin
      listing_d = is_list && !empty;
      pos_d     = '0;
    end else if (listing_q) begin
      listing_d = !last_list;
      pos_d     = pos_q + PW'(1);
    end
  end

  always_comb begin
    res_d.status         = ST_DONE;
    res_d.entry_value    = '0;
    res_d.entry_position = '0;
    res_d.occupancy      = 5'(count_d);
    res_d.last           = 1'b1;
    res_valid_d          = 1'b0;
    if (listing_q) begin
      res_valid_d          = 1'b1;
      res_d.status         = ST_LISTED;
      res_d.entry_value    = cell_val[0];
      res_d.entry_position = 4'(pos_q);
      res_d.last           = last_list;
    end else if (accept) begin
      res_valid_d = !(is_list && !empty);
      if (is_push && full) begin
        res_d.status = ST_FULL;
      end else if (is_remove && !found) begin
        res_d.status = ST_NOT_FOUND;
      end else if (is_list) begin
        res_d.status = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      listing_q   <= 1'b0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      listing_q   <= listing_d;
      pos_q       <= pos_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = listing_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
